// File: hdl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int SYM_W           = 8;
  localparam int STATUS_W        = 2;
  localparam int DIV_CNT_W       = $clog2(DATA_W);

  // expression bytes with a meaning of their own
  localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] SYM_NEG   = 8'h7E;
  localparam logic [SYM_W-1:0] SYM_ADD   = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB   = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_PUSH,
    CLS_NEG,
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_DIGIT
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPER,
    S_MULW,
    S_DIVW,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic push;
    logic neg;
    logic digit;
    logic alu;
    logic mul_start;
    logic mul_wb;
    logic div_start;
    logic div_wb;
    logic div0;
    logic flag_over;
    logic flag_under;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    cls_t cls;
    logic full;
    logic lt2;
    logic b_zero;
    logic last;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic cls_t decode_sym(input logic [SYM_W-1:0] sym);
    cls_t c;
    case (sym)
      SYM_SPACE: c = CLS_PUSH;
      SYM_NEG:   c = CLS_NEG;
      SYM_ADD:   c = CLS_ADD;
      SYM_SUB:   c = CLS_SUB;
      SYM_MUL:   c = CLS_MUL;
      SYM_DIV:   c = CLS_DIV;
      default:   c = CLS_DIGIT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pfe_in_if.sv
// ----------------------------------------------------------------------------
// pfe_in_if
// Expression byte channel: valid/ready handshake with one byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_in_if;
  logic                       valid;
  logic                       ready;
  logic [pfe_pkg::SYM_W-1:0]  symbol;
  logic                       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

`default_nettype wire

// File: hdl/pfe_out_if.sv
// ----------------------------------------------------------------------------
// pfe_out_if
// Result channel: valid/ready handshake carrying value and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pfe_pkg::DATA_W-1:0]   value;
  logic [pfe_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pfe_pkg::DATA_W-1:0]  num,
  input  wire logic [pfe_pkg::DATA_W-1:0]  den,
  output logic                             done,
  output logic      [pfe_pkg::DATA_W-1:0]  quot
);

  localparam int W  = pfe_pkg::DATA_W;
  localparam int CW = pfe_pkg::DIV_CNT_W;

  logic                            busy;
  logic [pfe_pkg::DIV_CNT_W-1:0]   cnt;
  logic [W-1:0]                    rem;
  logic [W-1:0]                    quo;
  logic [W-1:0]                    dmag;
  logic                            qneg;

  logic [W:0]   rem_sh;
  logic [W+1:0] diff;

  assign rem_sh = {rem, quo[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dmag};
  assign quot   = qneg ? (W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num[W-1] ? (W'(0) - num) : num;
      dmag <= den[W-1] ? (W'(0) - den) : den;
      qneg <= num[W-1] ^ den[W-1];
      cnt  <= CW'(W - 1);
    end else if (busy) begin
      // restoring step, dividend bits shift out of quo as quotient bits shift in
      if (!diff[W+1]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/pfe_datapath.sv
// ----------------------------------------------------------------------------
// pfe_datapath
// Stack storage, top register, arithmetic units and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_datapath #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire pfe_pkg::cmd_t cmd,
  output pfe_pkg::sts_t     sts,
  pfe_in_if.sink            expr,
  pfe_out_if.source         result
);

  localparam int W  = pfe_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [W-1:0]              top;
  logic [DW-1:0]             depth;
  pfe_pkg::status_t          sticky;
  logic [pfe_pkg::SYM_W-1:0] sym;
  logic                      last;
  logic [W-1:0]              prod;
  logic [W-1:0]              below;
  logic [DW-1:0]             depth_m1;
  logic [DW-1:0]             depth_m2;
  logic [W-1:0]              digit_val;
  logic                      div_done;
  logic [W-1:0]              div_q;
  logic                      out_valid;
  pfe_pkg::status_t          flag_code;
  logic                      flag_any;

  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);

  // entries under the top live in memory, the top itself in a register
  pfe_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth_m1[AW-1:0]),
    .wdata (top),
    .raddr (depth_m2[AW-1:0]),
    .rdata (below)
  );

  pfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (below),
    .den   (top),
    .done  (div_done),
    .quot  (div_q)
  );

  // top*10 as two shifts, plus the byte offset from ascii zero
  assign digit_val = {top[W-4:0], 3'b000} + {top[W-2:0], 1'b0}
                   + {{(W - pfe_pkg::SYM_W){1'b0}}, sym}
                   - {{(W - pfe_pkg::SYM_W){1'b0}}, pfe_pkg::SYM_ZERO};

  assign expr.ready = cmd.accept;

  assign sts.in_valid = expr.valid;
  assign sts.cls      = pfe_pkg::decode_sym(sym);
  assign sts.full     = (depth >= DW'(STACK_DEPTH));
  assign sts.lt2      = (depth < DW'(2));
  assign sts.b_zero   = (top == '0);
  assign sts.last     = last;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || result.ready;

  always_comb begin
    flag_any  = 1'b1;
    flag_code = pfe_pkg::ST_OK;
    if (cmd.flag_over) begin
      flag_code = pfe_pkg::ST_OVER;
    end else if (cmd.flag_under) begin
      flag_code = pfe_pkg::ST_UNDER;
    end else if (cmd.div0) begin
      flag_code = pfe_pkg::ST_DIV0;
    end else begin
      flag_any = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (expr.valid && cmd.accept) begin
      sym  <= expr.symbol;
      last <= expr.last_symbol;
    end
    if (cmd.mul_start) begin
      prod <= below * top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top    <= '0;
      depth  <= DW'(1);
      sticky <= pfe_pkg::ST_OK;
    end else begin
      if (cmd.emit) begin
        top    <= '0;
        depth  <= DW'(1);
        sticky <= pfe_pkg::ST_OK;
      end else begin
        if (flag_any && sticky == pfe_pkg::ST_OK) begin
          sticky <= flag_code;
        end
        if (cmd.push) begin
          top   <= '0;
          depth <= depth + DW'(1);
        end else if (cmd.neg) begin
          top <= W'(0) - top;
        end else if (cmd.digit) begin
          top <= digit_val;
        end else if (cmd.alu) begin
          top   <= (sts.cls == pfe_pkg::CLS_SUB) ? (below - top) : (below + top);
          depth <= depth_m1;
        end else if (cmd.mul_wb) begin
          top   <= prod;
          depth <= depth_m1;
        end else if (cmd.div_wb) begin
          top   <= div_q;
          depth <= depth_m1;
        end else if (cmd.div0) begin
          // zero divisor popped, dividend stays as the new top
          top   <= below;
          depth <= depth_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.value  <= top;
      result.status <= sticky;
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire

// File: hdl/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: walks one expression byte through decode, operand read and
// the selected arithmetic unit, then hands off the result when marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pfe_pkg::sts_t sts,
  output pfe_pkg::cmd_t      cmd
);

  pfe_pkg::state_t state;
  pfe_pkg::state_t state_next;
  pfe_pkg::state_t after_op;

  assign after_op = sts.last ? pfe_pkg::S_FINISH : pfe_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pfe_pkg::S_IDLE: begin
        if (sts.in_valid) begin
          state_next = pfe_pkg::S_DECODE;
        end
      end
      pfe_pkg::S_DECODE: begin
        case (sts.cls) inside
          pfe_pkg::CLS_ADD, pfe_pkg::CLS_SUB, pfe_pkg::CLS_MUL, pfe_pkg::CLS_DIV: begin
            state_next = sts.lt2 ? after_op : pfe_pkg::S_OPER;
          end
          default: state_next = after_op;
        endcase
      end
      pfe_pkg::S_OPER: begin
        if (sts.cls == pfe_pkg::CLS_MUL) begin
          state_next = pfe_pkg::S_MULW;
        end else if (sts.cls == pfe_pkg::CLS_DIV && !sts.b_zero) begin
          state_next = pfe_pkg::S_DIVW;
        end else begin
          state_next = after_op;
        end
      end
      pfe_pkg::S_MULW: state_next = after_op;
      pfe_pkg::S_DIVW: begin
        if (sts.div_done) begin
          state_next = after_op;
        end
      end
      pfe_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_next = pfe_pkg::S_IDLE;
        end
      end
      default: state_next = pfe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      pfe_pkg::S_IDLE: cmd.accept = 1'b1;
      pfe_pkg::S_DECODE: begin
        case (sts.cls)
          pfe_pkg::CLS_PUSH: begin
            if (sts.full) begin
              cmd.flag_over = 1'b1;
            end else begin
              cmd.push = 1'b1;
            end
          end
          pfe_pkg::CLS_NEG:   cmd.neg = 1'b1;
          pfe_pkg::CLS_DIGIT: cmd.digit = 1'b1;
          default: begin
            cmd.flag_under = sts.lt2;
          end
        endcase
      end
      pfe_pkg::S_OPER: begin
        case (sts.cls)
          pfe_pkg::CLS_MUL: cmd.mul_start = 1'b1;
          pfe_pkg::CLS_DIV: begin
            if (sts.b_zero) begin
              cmd.div0 = 1'b1;
            end else begin
              cmd.div_start = 1'b1;
            end
          end
          default: cmd.alu = 1'b1;
        endcase
      end
      pfe_pkg::S_MULW: cmd.mul_wb = 1'b1;
      pfe_pkg::S_DIVW: cmd.div_wb = sts.div_done;
      pfe_pkg::S_FINISH: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse Polish evaluator over a stack of 32-bit signed words.
// ----------------------------------------------------------------------------
// Usage:
//   expr carries one expression byte per word with a last_symbol mark;
//   result carries value and status, one word per expression, after the
//   byte marked last. Both channels use a valid/ready handshake.
//   One byte is worked on at a time. A space, '~' or digit byte passes
//   S_DECODE only; '+' and '-' go on to the operand state S_OPER, '*'
//   adds S_MULW and '/' waits in S_DIVW on the bit-serial divider (one
//   quotient bit a cycle) after the operand read from the stack memory.
//   A byte marked last adds S_FINISH to load the result register.
//   The result register parts the two sides: new bytes are taken while a
//   result waits; a second last byte waits only if the first result is
//   still not taken. Status is sticky for one expression and the stack,
//   depth and status return to a single zero after each result.
//   Reset (rst, synchronous) leaves the stack as a single zero, status ok
//   and no result pending; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pfe_in_if.sink    expr,
  pfe_out_if.source result
);

  pfe_pkg::cmd_t cmd;
  pfe_pkg::sts_t sts;

  pfe_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  pfe_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .expr   (expr),
    .result (result)
  );

endmodule

`default_nettype wire

// File: test/postfix_expression_evaluator_tb.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// Self-checking bench for the postfix evaluator. A directed set of
// expressions hits the arithmetic corners and all status codes but overflow.
// Random well-formed expressions, push floods and byte noise follow. A stack
// calculator in the bench predicts each result word, and the monitor checks
// every word against it. Both channels idle at random, and the result side
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_tb;

  typedef logic [pfe_pkg::SYM_W-1:0]  sym_t;
  typedef logic [pfe_pkg::DATA_W-1:0] word_t;

  typedef struct {
    sym_t symbol;
    logic last;
  } expr_byte_t;

  typedef struct {
    word_t             value;
    pfe_pkg::status_t  status;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst;

  pfe_in_if  expr ();
  pfe_out_if result ();

  postfix_expression_evaluator i_dut (
    .clk    (clk),
    .rst    (rst),
    .expr   (expr),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus and expectations
  expr_byte_t   pending_bytes[$];
  sym_t         draft[$];
  eval_result_t expected_results[$];

  // calculator state
  word_t             calc_stack[pfe_pkg::STACK_DEPTH_DEF];
  int unsigned       calc_depth;
  pfe_pkg::status_t  calc_status;

  int unsigned errors = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned calm_left = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;
  logic        expr_fire = 1'b0;

  function automatic void calc_reset();
    foreach (calc_stack[i]) calc_stack[i] = '0;
    calc_depth  = 1;
    calc_status = pfe_pkg::ST_OK;
  endfunction

  function automatic void note_error(input pfe_pkg::status_t code);
    if (calc_status == pfe_pkg::ST_OK) calc_status = code;
  endfunction

  function automatic void calc_step(input sym_t sym, input logic is_last);
    int unsigned  top;
    word_t        a;
    word_t        b;
    word_t        nm;
    word_t        dm;
    logic         neg_q;
    eval_result_t r;
    top = (calc_depth - 1) % pfe_pkg::STACK_DEPTH_DEF;
    case (sym)
      pfe_pkg::SYM_SPACE: begin
        if (calc_depth >= pfe_pkg::STACK_DEPTH_DEF) begin
          note_error(pfe_pkg::ST_OVER);
        end else begin
          calc_stack[calc_depth] = '0;
          calc_depth++;
        end
      end
      pfe_pkg::SYM_NEG: calc_stack[top] = -calc_stack[top];
      pfe_pkg::SYM_ADD, pfe_pkg::SYM_SUB, pfe_pkg::SYM_MUL, pfe_pkg::SYM_DIV: begin
        if (calc_depth < 2) begin
          note_error(pfe_pkg::ST_UNDER);
        end else begin
          b = calc_stack[top];
          a = calc_stack[top-1];
          calc_depth--;
          case (sym)
            pfe_pkg::SYM_ADD: a = a + b;
            pfe_pkg::SYM_SUB: a = a - b;
            pfe_pkg::SYM_MUL: a = a * b;
            default: begin
              if (b == '0) begin
                note_error(pfe_pkg::ST_DIV0);
              end else begin
                // magnitudes divided, sign put back: truncates toward zero
                neg_q = a[pfe_pkg::DATA_W-1] ^ b[pfe_pkg::DATA_W-1];
                nm = a[pfe_pkg::DATA_W-1] ? -a : a;
                dm = b[pfe_pkg::DATA_W-1] ? -b : b;
                a = nm / dm;
                if (neg_q) a = -a;
              end
            end
          endcase
          calc_stack[top-1] = a;
        end
      end
      default: begin
        calc_stack[top] = calc_stack[top] * 32'd10 + {24'd0, sym}
                        - {24'd0, pfe_pkg::SYM_ZERO};
      end
    endcase
    if (is_last) begin
      r.value  = calc_stack[(calc_depth - 1) % pfe_pkg::STACK_DEPTH_DEF];
      r.status = calc_status;
      expected_results.push_back(r);
      calc_reset();
    end
  endfunction

  // mostly short gaps, a few long ones, now and then a calm stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) calm_left = $urandom_range(40, 120);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void draft_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endfunction

  function automatic void draft_number();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 3);
    repeat (n) draft.push_back(sym_t'(pfe_pkg::SYM_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic sym_t random_binop();
    case ($urandom_range(0, 3))
      0: return pfe_pkg::SYM_ADD;
      1: return pfe_pkg::SYM_SUB;
      2: return pfe_pkg::SYM_MUL;
      default: return pfe_pkg::SYM_DIV;
    endcase
  endfunction

  // move the drafted bytes to the send queue, last mark on the final one
  function automatic void seal_expr();
    expr_byte_t eb;
    while (draft.size() != 0) begin
      eb.symbol = draft.pop_front();
      eb.last   = (draft.size() == 0);
      pending_bytes.push_back(eb);
    end
  endfunction

  function automatic void gen_well_formed();
    int unsigned depth;
    int unsigned r;
    depth = 1;
    draft_number();
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (depth >= 2 && r < 50) begin
        draft.push_back(random_binop());
        depth--;
      end else if (r < 60) begin
        draft.push_back(pfe_pkg::SYM_NEG);
      end else begin
        draft.push_back(pfe_pkg::SYM_SPACE);
        draft_number();
        depth++;
      end
    end
    seal_expr();
  endfunction

  // from 14 to 20 pushes, running past the top of the stack from the 16th on
  function automatic void gen_flood();
    repeat ($urandom_range(14, 20)) begin
      draft.push_back(pfe_pkg::SYM_SPACE);
      if ($urandom_range(0, 1)) begin
        draft.push_back(sym_t'(pfe_pkg::SYM_ZERO + $urandom_range(0, 9)));
      end
    end
    repeat ($urandom_range(0, 4)) draft.push_back(random_binop());
    seal_expr();
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 13))
        0: draft.push_back(pfe_pkg::SYM_SPACE);
        1: draft.push_back(pfe_pkg::SYM_NEG);
        2, 3, 4, 5: draft.push_back(random_binop());
        default: draft.push_back(sym_t'($urandom_range(0, 255)));
      endcase
    end
    seal_expr();
  endfunction

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      expr.valid <= 1'b0;
    end else if (expr.valid && !expr_fire) begin
      // word still offered
    end else if (send_gap != 0) begin
      expr.valid <= 1'b0;
      send_gap = send_gap - 1;
    end else if (pending_bytes.size() != 0) begin
      expr.valid       <= 1'b1;
      expr.symbol      <= pending_bytes[0].symbol;
      expr.last_symbol <= pending_bytes[0].last;
      pending_bytes.pop_front();
      send_gap = pick_gap();
    end else begin
      expr.valid <= 1'b0;
    end
  end

  // result side backpressure, with one long hold-off to fill the block
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 25) begin
      long_hold_done = 1'b1;
      hold_left = 500;
      result.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) hold_left = pick_gap();
    end
  end

  // prediction on accepted bytes, checking on accepted results
  always @(posedge clk) begin
    eval_result_t want;
    expr_fire <= !rst && expr.valid && expr.ready;
    if (!rst && expr.valid && expr.ready) begin
      bytes_taken++;
      calc_step(expr.symbol, expr.last_symbol);
    end
    if (!rst && result.valid && result.ready) begin
      results_seen++;
      status_seen[result.status]++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual value %0d status %0d",
                 $time, $signed(result.value), result.status);
      end else begin
        want = expected_results.pop_front();
        if (result.value !== want.value) begin
          errors++;
          $display("%0t: value mismatch, expected %0d actual %0d",
                   $time, $signed(want.value), $signed(result.value));
        end
        if (result.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, result.status);
        end
      end
    end
  end

  initial begin
    int unsigned kind;
    rst              = 1'b1;
    expr.valid       = 1'b0;
    expr.symbol      = '0;
    expr.last_symbol = 1'b0;
    result.ready     = 1'b0;
    calc_reset();

    // lone operator: underflow
    draft_text("+");
    seal_expr();
    // divide by zero, then an underflow that must not replace it
    draft_text("9 0/-");
    seal_expr();
    // max positive wraps on add, most negative divided by minus one
    draft_text("2147483647 1+~ 1~/");
    seal_expr();
    // non-digit bytes at both ends of the range fold as offsets
    draft.push_back(8'hFF);
    draft.push_back(pfe_pkg::SYM_SPACE);
    draft.push_back(8'h00);
    draft.push_back(pfe_pkg::SYM_MUL);
    seal_expr();

    while (pending_bytes.size() < 830) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) gen_well_formed();
      else if (kind < 85) gen_flood();
      else gen_noise();
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || expr.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d bytes and %0d results, with random idling and one long result stall",
             bytes_taken, results_seen);
    $display("statuses seen: ok %0d, div by zero %0d, underflow %0d, overflow %0d",
             status_seen[pfe_pkg::ST_OK], status_seen[pfe_pkg::ST_DIV0],
             status_seen[pfe_pkg::ST_UNDER], status_seen[pfe_pkg::ST_OVER]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
